@@ rtl/core/g2p_pkg.sv @@
// ----------------------------------------------------------------------------
// g2p_pkg
// shared types, constants and month tables for the gregorian to persian
// date converter
// ----------------------------------------------------------------------------
package g2p_pkg;

  // payload of one input item
  typedef struct packed {
    logic [11:0] greg_year;
    logic [3:0]  greg_month;
    logic [4:0]  greg_day;
  } greg_date_t;

  // payload of one result item
  typedef struct packed {
    logic [11:0] pers_year;
    logic [3:0]  pers_month;
    logic [4:0]  pers_day;
  } pers_date_t;

  // day number handed from the day counter to the cycle splitter
  typedef struct packed {
    logic        valid;
    logic [19:0] days;
  } g2p_daynum_t;

  localparam int unsigned DayNumW = 20;

  // calendar constants
  localparam logic [11:0] GregYearMin  = 12'd1601;
  localparam logic [11:0] GregEpoch    = 12'd1600;
  localparam logic [3:0]  MonthFirst   = 4'd1;
  localparam logic [3:0]  MonthLast    = 4'd12;
  localparam logic [6:0]  NewYearShift = 7'd80;   // 79 plus the day-of-month base
  localparam logic [11:0] PersYearBase = 12'd979;

  localparam logic [13:0] CycleDays    = 14'd12053;  // 33 persian years
  localparam logic [10:0] QuadDays     = 11'd1461;   // 4 persian years
  localparam logic [8:0]  YearDays     = 9'd365;
  localparam logic [8:0]  LeapYearDays = 9'd366;

  // reciprocals for division by constants
  // floor(x / 100)   = (x * 5243) >> 19, exact for x below 4096
  // floor(x / 12053) = (x * 1425361) >> 34, exact for 20-bit x
  // floor(x / 1461)  = (x * 22967) >> 25, exact for x below 12053
  localparam logic [12:0] Recip100   = 13'd5243;
  localparam int unsigned Shift100   = 19;
  localparam logic [20:0] RecipCycle = 21'd1425361;
  localparam int unsigned ShiftCycle = 34;
  localparam logic [14:0] RecipQuad  = 15'd22967;
  localparam int unsigned ShiftQuad  = 25;

  // days in the gregorian year before month index gm (0 is january)
  function automatic logic [8:0] greg_cum_days(input logic [3:0] gm);
    logic [8:0] d;
    case (gm)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd59;
      4'd3:    d = 9'd90;
      4'd4:    d = 9'd120;
      4'd5:    d = 9'd151;
      4'd6:    d = 9'd181;
      4'd7:    d = 9'd212;
      4'd8:    d = 9'd243;
      4'd9:    d = 9'd273;
      4'd10:   d = 9'd304;
      4'd11:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

  // days in the persian year before month index pm (0 is farvardin)
  function automatic logic [8:0] pers_cum_days(input logic [3:0] pm);
    logic [8:0] d;
    case (pm)
      4'd0:    d = 9'd0;
      4'd1:    d = 9'd31;
      4'd2:    d = 9'd62;
      4'd3:    d = 9'd93;
      4'd4:    d = 9'd124;
      4'd5:    d = 9'd155;
      4'd6:    d = 9'd186;
      4'd7:    d = 9'd216;
      4'd8:    d = 9'd246;
      4'd9:    d = 9'd276;
      4'd10:   d = 9'd306;
      4'd11:   d = 9'd336;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage

@@ rtl/core/g2p_day_count.sv @@
// ----------------------------------------------------------------------------
// g2p_day_count
// three-stage pipeline from a gregorian date to a day number counted from
// the persian new year in march 1600
// ----------------------------------------------------------------------------
module g2p_day_count import g2p_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  greg_date_t  date_i,
  output g2p_daynum_t day_o
);

  // stage 1: clamped fields
  logic        s1_valid_q;
  logic [11:0] s1_gy_q, s1_gy_d;
  logic [3:0]  s1_gm_q, s1_gm_d;
  logic [4:0]  s1_day_q;

  // stage 2: year days, leap days, month offset
  logic        s2_valid_q;
  logic [20:0] s2_y365_q, s2_y365_d;
  logic [10:0] s2_leapd_q, s2_leapd_d;
  logic [8:0]  s2_cum_q, s2_cum_d;
  logic [4:0]  s2_day_q;

  // stage 3: day number
  logic        s3_valid_q;
  logic [19:0] s3_days_q, s3_days_d;

  logic [24:0] cent_lo_prod;
  logic [25:0] cent_hi_prod;
  logic [6:0]  cent_lo;    // floor(gy / 100)
  logic [6:0]  cent_hi;    // ceil(gy / 100)
  logic        is_leap;

  always_comb begin
    logic [11:0] year_c;
    logic [3:0]  mon_c;
    year_c  = (date_i.greg_year < GregYearMin) ? GregYearMin : date_i.greg_year;
    mon_c   = date_i.greg_month;
    if (mon_c < MonthFirst) begin
      mon_c = MonthFirst;
    end
    if (mon_c > MonthLast) begin
      mon_c = MonthLast;
    end
    s1_gy_d = year_c - GregEpoch;
    s1_gm_d = mon_c - MonthFirst;
  end

  always_comb begin
    cent_lo_prod = 25'(s1_gy_q) * 25'(Recip100);
    cent_hi_prod = (26'(s1_gy_q) + 26'd99) * 26'(Recip100);
    cent_lo      = cent_lo_prod[Shift100 +: 6] == 6'd0 ? 7'd0
                   : {1'b0, cent_lo_prod[Shift100 +: 6]};
    cent_hi      = cent_hi_prod[Shift100 +: 7];
    // gy % 100 == 0 exactly when floor and ceil of gy / 100 agree
    is_leap      = (s1_gy_q[1:0] == 2'd0) &&
                   ((cent_hi != cent_lo) || (cent_lo[1:0] == 2'd0));
    s2_y365_d    = 21'(s1_gy_q) * 21'(YearDays);
    // (gy+3)/4 - (gy+99)/100 + (gy+399)/400
    s2_leapd_d   = 11'((13'(s1_gy_q) + 13'd3) >> 2) - 11'(cent_hi)
                   + 11'((8'(cent_hi) + 8'd3) >> 2);
    s2_cum_d     = greg_cum_days(s1_gm_q) + ((s1_gm_q > 4'd1 && is_leap) ? 9'd1 : 9'd0);
  end

  always_comb begin
    logic [20:0] sum;
    sum       = s2_y365_q + 21'(s2_leapd_q) + 21'(s2_cum_q) + 21'(s2_day_q)
                - 21'(NewYearShift);
    s3_days_d = sum[DayNumW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_gy_q    <= s1_gy_d;
    s1_gm_q    <= s1_gm_d;
    s1_day_q   <= date_i.greg_day;
    s2_y365_q  <= s2_y365_d;
    s2_leapd_q <= s2_leapd_d;
    s2_cum_q   <= s2_cum_d;
    s2_day_q   <= s1_day_q;
    s3_days_q  <= s3_days_d;
  end

  assign day_o.valid = s3_valid_q;
  assign day_o.days  = s3_days_q;

endmodule

@@ rtl/core/g2p_cycle_split.sv @@
// ----------------------------------------------------------------------------
// g2p_cycle_split
// six-stage pipeline that splits a day number into 33-year cycles, 4-year
// groups, years and months of the persian calendar
// ----------------------------------------------------------------------------
module g2p_cycle_split import g2p_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  g2p_daynum_t day_i,
  output logic        valid_o,
  output pers_date_t  date_o
);

  // stage 4: cycle quotient
  logic        s4_valid_q;
  logic [6:0]  s4_q33_q, s4_q33_d;
  logic [19:0] s4_days_q;
  logic [40:0] cyc_prod;

  // stage 5: remainder within the cycle
  logic        s5_valid_q;
  logic [13:0] s5_rem_q, s5_rem_d;
  logic [11:0] s5_yr_q, s5_yr_d;

  // stage 6: group quotient
  logic        s6_valid_q;
  logic [3:0]  s6_q4_q, s6_q4_d;
  logic [13:0] s6_rem_q;
  logic [11:0] s6_yr_q;
  logic [28:0] quad_prod;

  // stage 7: remainder within the group
  logic        s7_valid_q;
  logic [10:0] s7_rem_q, s7_rem_d;
  logic [11:0] s7_yr_q, s7_yr_d;

  // stage 8: day of persian year
  logic        s8_valid_q;
  logic [8:0]  s8_doy_q, s8_doy_d;
  logic [11:0] s8_yr_q, s8_yr_d;

  // stage 9: result register
  logic        s9_valid_q;
  pers_date_t  s9_date_q, s9_date_d;

  always_comb begin
    cyc_prod = 41'(day_i.days) * 41'(RecipCycle);
    s4_q33_d = cyc_prod[ShiftCycle +: 7];
  end

  always_comb begin
    logic [20:0] sub;
    sub      = 21'(s4_q33_q) * 21'(CycleDays);
    s5_rem_d = 14'(21'(s4_days_q) - sub);
    s5_yr_d  = PersYearBase + 12'({s4_q33_q, 5'b0}) + 12'(s4_q33_q);
  end

  always_comb begin
    quad_prod = 29'(s5_rem_q) * 29'(RecipQuad);
    s6_q4_d   = quad_prod[ShiftQuad +: 4];
  end

  always_comb begin
    logic [14:0] sub;
    sub      = 15'(s6_q4_q) * 15'(QuadDays);
    s7_rem_d = 11'(15'(s6_rem_q) - sub);
    s7_yr_d  = s6_yr_q + 12'({s6_q4_q, 2'b0});
  end

  // the first year of a group has 366 days, the other three 365
  always_comb begin
    logic [10:0] t;
    t        = s7_rem_q - 11'd1;
    s8_yr_d  = s7_yr_q;
    s8_doy_d = s7_rem_q[8:0];
    if (s7_rem_q >= 11'(LeapYearDays)) begin
      if (t >= 11'd1095) begin
        s8_yr_d  = s7_yr_q + 12'd3;
        s8_doy_d = 9'(t - 11'd1095);
      end else if (t >= 11'd730) begin
        s8_yr_d  = s7_yr_q + 12'd2;
        s8_doy_d = 9'(t - 11'd730);
      end else begin
        s8_yr_d  = s7_yr_q + 12'd1;
        s8_doy_d = 9'(t - 11'(YearDays));
      end
    end
  end

  // month index is the last month start not above the day of year
  always_comb begin
    logic [3:0] cnt;
    cnt = 4'd0;
    for (int k = 1; k < 12; k++) begin
      if (s8_doy_q >= pers_cum_days(4'(k))) begin
        cnt = 4'(k);
      end
    end
    s9_date_d.pers_year  = s8_yr_q;
    s9_date_d.pers_month = cnt + MonthFirst;
    s9_date_d.pers_day   = 5'(s8_doy_q - pers_cum_days(cnt) + 9'd1);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_valid_q <= 1'b0;
      s5_valid_q <= 1'b0;
      s6_valid_q <= 1'b0;
      s7_valid_q <= 1'b0;
      s8_valid_q <= 1'b0;
      s9_valid_q <= 1'b0;
    end else begin
      s4_valid_q <= day_i.valid;
      s5_valid_q <= s4_valid_q;
      s6_valid_q <= s5_valid_q;
      s7_valid_q <= s6_valid_q;
      s8_valid_q <= s7_valid_q;
      s9_valid_q <= s8_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s4_q33_q  <= s4_q33_d;
    s4_days_q <= day_i.days;
    s5_rem_q  <= s5_rem_d;
    s5_yr_q   <= s5_yr_d;
    s6_q4_q   <= s6_q4_d;
    s6_rem_q  <= s5_rem_q;
    s6_yr_q   <= s5_yr_q;
    s7_rem_q  <= s7_rem_d;
    s7_yr_q   <= s7_yr_d;
    s8_doy_q  <= s8_doy_d;
    s8_yr_q   <= s8_yr_d;
    s9_date_q <= s9_date_d;
  end

  assign valid_o = s9_valid_q;
  assign date_o  = s9_date_q;

endmodule

@@ rtl/core/gregorian_to_persian_date.sv @@
// ----------------------------------------------------------------------------
// gregorian_to_persian_date
// converts a gregorian date into the persian (jalali) date using the
// arithmetic 33-year cycle
// ----------------------------------------------------------------------------
// usage
//   input channel: drive greg_i and raise start; the item is taken at any
//   rising edge where start is high and busy is low. busy never rises, so
//   a new date can be taken on every cycle, back to back
//   result channel: done_o is high for exactly one cycle with the matching
//   persian date on pers_o; the receiver takes it at the end of that cycle
//   and cannot stall it, so nothing ever backs up into the input side
//   pipeline: nine register stages, and done_o is driven by the last of them;
//   results leave in input order
//   throughput: one item per cycle, set by the fully pipelined datapath
//   (three stages build the day number, six split it into cycles, groups,
//   years and months, the last of them is the result register)
//   years below 1601 count as 1601, months outside 1..12 are clamped, and
//   days are not checked: an odd day just moves the day count
//   reset: rst_ni clears the stage valid flags at once, so items in flight
//   are dropped and no done_o pulse follows reset
// ----------------------------------------------------------------------------
module gregorian_to_persian_date import g2p_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  greg_date_t greg_i,
  output logic       done_o,
  output pers_date_t pers_o
);

  g2p_daynum_t day_num;
  logic        accept;

  // every stage advances each cycle, so the input side is always open
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  // gregorian date to day number
  g2p_day_count u_day_count (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (accept),
    .date_i     (greg_i),
    .day_o      (day_num)
  );

  // day number to persian year, month and day
  g2p_cycle_split u_cycle_split (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .day_i   (day_num),
    .valid_o (done_o),
    .date_o  (pers_o)
  );

  // fixed latency from accept to result
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##9 done_o)
    else $error("result missing nine cycles after accept");

  // no result without a matching item taken before it
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, 9))
    else $error("result without a matching item");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pers_o.pers_month >= MonthFirst) && (pers_o.pers_month <= MonthLast))
    else $error("persian month out of range");

  // first six months have 31 days, the rest at most 30
  a_day_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (pers_o.pers_day >= 5'd1) &&
               ((pers_o.pers_month <= 4'd6) || (pers_o.pers_day <= 5'd30)))
    else $error("persian day out of range for its month");

endmodule

@@ verif/tb_gregorian_to_persian_date.sv @@
// ----------------------------------------------------------------------------
// tb_gregorian_to_persian_date
// self-checking bench for the gregorian to persian date converter: calendar
// corner dates first, then random dates with and without sender gaps, each
// result checked field by field against an in-bench 33-year-cycle predictor
// ----------------------------------------------------------------------------
module tb_gregorian_to_persian_date;
  timeunit 1ns;
  timeprecision 1ps;

  import g2p_pkg::*;

  localparam int ClkPeriod   = 20;
  localparam int ResetCycles = 11;
  // nine register stages, plus a little slack
  localparam int DrainCycles = 16;
  localparam int MaxReported = 10;
  localparam int RandomItems = 250;
  // far beyond the slowest correct run (about 800 items, short gaps)
  localparam int TimeoutCycles = 200000;

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  greg_date_t greg_i;
  logic       done_o;
  pers_date_t pers_o;

  // persian dates still owed by the converter, oldest first
  pers_date_t  pending_pers_dates[$];
  int unsigned mismatch_count;
  // chance in percent that the sender idles before the next item
  int unsigned sender_idle_pct;

  gregorian_to_persian_date i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .greg_i (greg_i),
    .done_o (done_o),
    .pers_o (pers_o)
  );

  // free-running clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // hard stop in case the converter hangs or drops results
  initial begin
    #(ClkPeriod * TimeoutCycles);
    $display("gregorian_to_persian_date test failed");
    $finish;
  end

  // predicted persian date for one gregorian date, 33-year cycle arithmetic
  function automatic pers_date_t persian_date_of(input greg_date_t g);
    int         yr;
    int         mon;
    int         gy;
    int         days;
    int         pyear;
    int         months_done;
    int         m;
    int         len;
    pers_date_t p;
    yr  = int'(g.greg_year);
    mon = int'(g.greg_month);
    // out-of-range years and months are clamped, days are never checked
    if (yr < 1601) yr = 1601;
    if (mon < 1) mon = 1;
    if (mon > 12) mon = 12;
    gy = yr - 1600;
    // days since the start of 1600 up to the first of january of yr
    days = 365 * gy + (gy + 3) / 4 - (gy + 99) / 100 + (gy + 399) / 400;
    for (m = 0; m < mon - 1; m++) begin
      if (m == 1) len = 28;
      else if (m == 3 || m == 5 || m == 8 || m == 10) len = 30;
      else len = 31;
      days += len;
    end
    // 1600 is a multiple of 400, so gy carries the leap rule of yr
    if (mon > 2 && (((gy % 4 == 0) && (gy % 100 != 0)) || (gy % 400 == 0)))
      days++;
    days += int'(g.greg_day) - 1;
    // shift so that day zero is a persian new year
    days -= 79;
    pyear = 979 + 33 * (days / 12053);
    days  = days % 12053;
    pyear += 4 * (days / 1461);
    days  = days % 1461;
    // the first year of each four-year group is the long one
    if (days >= 366) begin
      pyear += (days - 1) / 365;
      days  = (days - 1) % 365;
    end
    // six 31-day months, then 30-day months, the last month takes the rest
    months_done = 0;
    while (months_done < 11 && days >= ((months_done < 6) ? 31 : 30)) begin
      days -= (months_done < 6) ? 31 : 30;
      months_done++;
    end
    p.pers_year  = pyear[11:0];
    p.pers_month = 4'(months_done + 1);
    p.pers_day   = 5'(days + 1);
    return p;
  endfunction

  // a random date: mostly well inside the range, sometimes clamped or odd
  function automatic greg_date_t random_greg_date();
    greg_date_t g;
    g.greg_year  = ($urandom_range(99) < 90) ? 12'($urandom_range(4095, 1601))
                                             : 12'($urandom_range(1600, 0));
    g.greg_month = ($urandom_range(99) < 90) ? 4'($urandom_range(12, 1))
                                             : 4'($urandom_range(15, 0));
    g.greg_day   = ($urandom_range(99) < 90) ? 5'($urandom_range(31, 1))
                                             : 5'($urandom_range(31, 0));
    return g;
  endfunction

  // hands one date to the converter, with a random idle gap before it
  task automatic send_date(input greg_date_t g);
    bit taken;
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    start  <= 1'b1;
    greg_i <= g;
    taken  = 1'b0;
    // busy is sampled mid-cycle, the item is taken at the following edge
    while (!taken) begin
      @(negedge clk_i);
      taken = !busy;
      @(posedge clk_i);
    end
    pending_pers_dates.push_back(persian_date_of(g));
  endtask

  // stop sending and wait until every owed result has come back
  task automatic wait_for_results();
    start <= 1'b0;
    while (pending_pers_dates.size() != 0) @(posedge clk_i);
  endtask

  task automatic report_failure(input string what, input pers_date_t want);
    mismatch_count++;
    if (mismatch_count <= MaxReported)
      $display("%0t: %s: expected %0d-%0d-%0d, got %0d-%0d-%0d", $realtime, what,
               want.pers_year, want.pers_month, want.pers_day,
               pers_o.pers_year, pers_o.pers_month, pers_o.pers_day);
  endtask

  // result checker: done_o is sampled mid-cycle, away from the clock edge
  always @(negedge clk_i) begin
    pers_date_t want;
    if (rst_ni && done_o) begin
      if (pending_pers_dates.size() == 0) begin
        want = '0;
        report_failure("result with no date pending", want);
      end else begin
        want = pending_pers_dates.pop_front();
        if (pers_o.pers_year != want.pers_year || pers_o.pers_month != want.pers_month
            || pers_o.pers_day != want.pers_day)
          report_failure("wrong persian date", want);
      end
    end
  end

  // calendar corners: clamping, field extremes, leap days, new year edges
  task automatic test_calendar_corners();
    sender_idle_pct = 0;
    send_date('{12'd1601, 4'd1, 5'd1});    // first date in range
    send_date('{12'd0, 4'd1, 5'd1});       // year far below range, all zero bits
    send_date('{12'd1600, 4'd12, 5'd31});  // last year below range
    send_date('{12'd1234, 4'd5, 5'd6});
    send_date('{12'd4095, 4'd12, 5'd31});  // latest date, year and day all ones
    send_date('{12'd4095, 4'd15, 5'd31});  // month above twelve
    send_date('{12'd2000, 4'd13, 5'd0});
    send_date('{12'd2000, 4'd0, 5'd0});    // month zero and day zero
    send_date('{12'd4095, 4'd0, 5'd0});
    send_date('{12'd2000, 4'd2, 5'd29});   // leap day in a 400 year
    send_date('{12'd1900, 4'd2, 5'd29});   // no leap day in a plain century
    send_date('{12'd2100, 4'd3, 5'd1});
    // pause until the pipeline is empty, then continue back to back
    wait_for_results();
    send_date('{12'd2024, 4'd3, 5'd19});   // last day of the persian year
    send_date('{12'd2024, 4'd3, 5'd20});   // persian new year
    send_date('{12'd2023, 4'd3, 5'd20});
    send_date('{12'd2025, 4'd3, 5'd20});
    send_date('{12'd2025, 4'd3, 5'd21});
    send_date('{12'd2024, 4'd9, 5'd22});   // first day after the 31-day months
    send_date('{12'd2024, 4'd9, 5'd23});
    send_date('{12'd2016, 4'd12, 5'd21});
    send_date('{12'd2024, 4'd12, 5'd31});
    send_date('{12'd3000, 4'd6, 5'd31});   // day past the end of the month
    send_date('{12'd1601, 4'd2, 5'd28});
    wait_for_results();
  endtask

  task automatic run_random_dates(input int unsigned idle_pct);
    sender_idle_pct = idle_pct;
    repeat (RandomItems) send_date(random_greg_date());
    wait_for_results();
  endtask

  task automatic test_random_with_short_gaps();
    run_random_dates(26);
  endtask

  task automatic test_random_with_long_gaps();
    run_random_dates(45);
  endtask

  task automatic test_random_back_to_back();
    run_random_dates(0);
  endtask

  initial begin
    rst_ni          = 1'b0;
    start           = 1'b0;
    greg_i          = '0;
    mismatch_count  = 0;
    sender_idle_pct = 0;
    repeat (ResetCycles) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_calendar_corners();
    test_random_with_short_gaps();
    test_random_with_long_gaps();
    test_random_back_to_back();

    // let any stray result surface before the verdict
    repeat (DrainCycles) @(posedge clk_i);
    if (mismatch_count == 0 && pending_pers_dates.size() == 0) begin
      $display("gregorian_to_persian_date test passed");
    end else begin
      $display("gregorian_to_persian_date test failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
rtl/core/g2p_pkg.sv
rtl/core/g2p_day_count.sv
rtl/core/g2p_cycle_split.sv
rtl/core/gregorian_to_persian_date.sv
verif/tb_gregorian_to_persian_date.sv
